@@ design/sva_pkg.sv @@
// ----------------------------------------------------------------------------
// sva_pkg
// request and action codes, field widths and the structs that travel along
// the voice cell chain
// ----------------------------------------------------------------------------
package sva_pkg;

    localparam int REQ_W   = 3;
    localparam int NOTE_W  = 7;
    localparam int SLOT_W  = 3;
    localparam int ACT_W   = 3;
    localparam int OUT_IDX_W = 3;
    localparam int OUT_CNT_W = 4;
    localparam int AGE_W   = 32;
    // sized for the largest supported voice count (64)
    localparam int IDX_W   = 6;
    localparam int CNT_W   = 7;

    localparam logic [AGE_W-1:0] AGE_MAX = {AGE_W{1'b1}};

    localparam logic [REQ_W-1:0] REQ_NOTE_ON    = 3'd0;
    localparam logic [REQ_W-1:0] REQ_NOTE_OFF   = 3'd1;
    localparam logic [REQ_W-1:0] REQ_TICK       = 3'd2;
    localparam logic [REQ_W-1:0] REQ_VOICE_DONE = 3'd3;
    localparam logic [REQ_W-1:0] REQ_ALL_OFF    = 3'd4;

    localparam logic [ACT_W-1:0] ACT_FREE_START   = 3'd0;
    localparam logic [ACT_W-1:0] ACT_STOLEN       = 3'd1;
    localparam logic [ACT_W-1:0] ACT_DROPPED      = 3'd2;
    localparam logic [ACT_W-1:0] ACT_RELEASED     = 3'd3;
    localparam logic [ACT_W-1:0] ACT_NOT_FOUND    = 3'd4;
    localparam logic [ACT_W-1:0] ACT_AGED         = 3'd5;
    localparam logic [ACT_W-1:0] ACT_FREED        = 3'd6;
    localparam logic [ACT_W-1:0] ACT_ALL_RELEASED = 3'd7;

    // search token handed from cell to cell, one cell per cycle
    typedef struct packed {
        logic              valid;
        logic [REQ_W-1:0]  req;
        logic [NOTE_W-1:0] note;
        logic [SLOT_W-1:0] slot;
        logic              free_found;
        logic [IDX_W-1:0]  free_idx;
        logic              best_have;
        logic [AGE_W-1:0]  best_age;
        logic [IDX_W-1:0]  best_idx;
        logic              hit_found;
        logic [IDX_W-1:0]  hit_idx;
        logic              slot_active;
        logic [CNT_W-1:0]  count;
    } t_scan;

    // update broadcast to all cells when a scan ends
    typedef struct packed {
        logic              tick;
        logic              wr;
        logic              free;
        logic [IDX_W-1:0]  idx;
        logic [NOTE_W-1:0] note;
    } t_cmd;

endpackage

@@ design/sva_cell.sv @@
// ----------------------------------------------------------------------------
// sva_cell
// one voice: active mark, note and age, plus one stage of the search chain
// ----------------------------------------------------------------------------
module sva_cell #(
    parameter int IDX = 0
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  sva_pkg::t_scan i_scan,
    output sva_pkg::t_scan o_scan,
    input  sva_pkg::t_cmd  i_cmd
);

    localparam logic [sva_pkg::IDX_W-1:0] MY_IDX = sva_pkg::IDX_W'(IDX);

    logic                          r_active;
    logic [sva_pkg::NOTE_W-1:0]    r_note;
    logic [sva_pkg::AGE_W-1:0]     r_age;
    sva_pkg::t_scan                r_scan;
    sva_pkg::t_scan                n_scan;
    logic                          w_sel;

    assign w_sel = (i_cmd.idx == MY_IDX);

    // fold this voice into the passing token
    always_comb begin
        n_scan = i_scan;
        if (!i_scan.free_found && !r_active) begin
            n_scan.free_found = 1'b1;
            n_scan.free_idx   = MY_IDX;
        end
        if (r_age > i_scan.best_age) begin
            n_scan.best_have = 1'b1;
            n_scan.best_age  = r_age;
            n_scan.best_idx  = MY_IDX;
        end
        if (!i_scan.hit_found && r_active && (r_note == i_scan.note)) begin
            n_scan.hit_found = 1'b1;
            n_scan.hit_idx   = MY_IDX;
        end
        if ({{(sva_pkg::IDX_W-sva_pkg::SLOT_W){1'b0}}, i_scan.slot} == MY_IDX) begin
            n_scan.slot_active = r_active;
        end
        n_scan.count = i_scan.count + sva_pkg::CNT_W'(r_active);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active     <= 1'b0;
            r_age        <= '0;
            r_scan.valid <= 1'b0;
        end else begin
            r_scan <= n_scan;
            if (i_cmd.wr && w_sel) begin
                r_active <= 1'b1;
                r_age    <= '0;
            end else if (i_cmd.free && w_sel) begin
                r_active <= 1'b0;
            end else if (i_cmd.tick && r_active && (r_age != sva_pkg::AGE_MAX)) begin
                r_age <= r_age + 1'b1;
            end
        end
    end

    // note is payload, no reset
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr && w_sel) begin
            r_note <= i_cmd.note;
        end
    end

    assign o_scan = r_scan;

endmodule

@@ design/synth_voice_allocator.sv @@
// ----------------------------------------------------------------------------
// synth_voice_allocator
// polyphonic voice allocator with oldest-voice stealing
// ----------------------------------------------------------------------------
// Each request beat enters a chain of VOICES voice cells as a search token
// that moves one cell per cycle, picking up the first free voice, the
// oldest voice, the first voice holding the note, the state of the named
// slot and the active count. When the token leaves the last cell the
// controller decides, broadcasts at most one update to all cells and loads
// the result register in the same cycle; o_ready rises again in the next
// cycle. A result waiting on i_ready does not block the next request from
// entering the chain; only the final commit waits for the result register
// to empty, with the finished token parked in a tail register and o_ready
// low until the waiting result beat is taken. Request codes above all_off
// are taken and give no result.
// ----------------------------------------------------------------------------
module synth_voice_allocator #(
    parameter int VOICES = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // request channel
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [sva_pkg::REQ_W-1:0]     i_req_type,
    input  logic [sva_pkg::NOTE_W-1:0]    i_note_number,
    input  logic [sva_pkg::SLOT_W-1:0]    i_voice_slot,
    // result channel
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [sva_pkg::OUT_IDX_W-1:0] o_voice_chosen,
    output logic [sva_pkg::ACT_W-1:0]     o_action,
    output logic [sva_pkg::OUT_CNT_W-1:0] o_active_voices
);

    typedef enum logic {
        S_IDLE,
        S_SCAN
    } t_state;

    t_state                        r_state;
    logic                          r_o_valid;
    logic [sva_pkg::IDX_W-1:0]     r_chosen;
    logic [sva_pkg::ACT_W-1:0]     r_action;
    logic [sva_pkg::CNT_W-1:0]     r_count;
    sva_pkg::t_scan                r_tail;

    logic                          w_in_beat;
    logic                          w_known;
    logic                          w_done;
    logic                          w_commit;
    sva_pkg::t_scan                w_head;
    sva_pkg::t_scan                w_scan [0:VOICES];
    sva_pkg::t_scan                w_last;
    sva_pkg::t_cmd                 w_cmd;
    logic [VOICES-1:0]             w_chain_valid;
    logic [sva_pkg::IDX_W-1:0]     n_chosen;
    logic [sva_pkg::ACT_W-1:0]     n_action;
    logic [sva_pkg::CNT_W-1:0]     n_count;

    assign o_ready   = (r_state == S_IDLE);
    assign w_in_beat = i_valid && o_ready;
    // unknown request codes are swallowed here
    assign w_known   = (i_req_type == sva_pkg::REQ_NOTE_ON)
                    || (i_req_type == sva_pkg::REQ_NOTE_OFF)
                    || (i_req_type == sva_pkg::REQ_TICK)
                    || (i_req_type == sva_pkg::REQ_VOICE_DONE)
                    || (i_req_type == sva_pkg::REQ_ALL_OFF);

    // fresh search token for the head of the chain
    always_comb begin
        w_head       = '0;
        w_head.valid = w_in_beat && w_known;
        w_head.req   = i_req_type;
        w_head.note  = i_note_number;
        w_head.slot  = i_voice_slot;
    end

    assign w_scan[0] = w_head;

    // the voice chain
    for (genvar g = 0; g < VOICES; g++) begin : g_cell
        sva_cell #(
            .IDX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_scan  (w_scan[g]),
            .o_scan  (w_scan[g+1]),
            .i_cmd   (w_cmd)
        );
        assign w_chain_valid[g] = w_scan[g+1].valid;
    end

    // a parked token takes the place of the chain output
    assign w_last   = r_tail.valid ? r_tail : w_scan[VOICES];
    assign w_done   = (r_state == S_SCAN) && w_last.valid;
    // hold the token at the tail until the result register can take it
    assign w_commit = w_done && (!r_o_valid || i_ready);

    // park a finished token while the result register is still full
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tail.valid <= 1'b0;
        end else if (w_done && !w_commit) begin
            r_tail <= w_last;
        end else begin
            r_tail.valid <= 1'b0;
        end
    end

    // decision at the tail of the chain
    always_comb begin
        w_cmd      = '0;
        w_cmd.note = w_last.note;
        n_chosen   = '0;
        n_action   = sva_pkg::ACT_ALL_RELEASED;
        n_count    = w_last.count;
        case (w_last.req)
            sva_pkg::REQ_NOTE_ON: begin
                if (w_last.free_found) begin
                    w_cmd.wr  = w_commit;
                    w_cmd.idx = w_last.free_idx;
                    n_chosen  = w_last.free_idx;
                    n_action  = sva_pkg::ACT_FREE_START;
                    n_count   = w_last.count + 1'b1;
                end else if (w_last.best_have) begin
                    // every voice busy: steal the oldest
                    w_cmd.wr  = w_commit;
                    w_cmd.idx = w_last.best_idx;
                    n_chosen  = w_last.best_idx;
                    n_action  = sva_pkg::ACT_STOLEN;
                end else begin
                    n_action  = sva_pkg::ACT_DROPPED;
                end
            end
            sva_pkg::REQ_NOTE_OFF: begin
                if (w_last.hit_found) begin
                    n_chosen = w_last.hit_idx;
                    n_action = sva_pkg::ACT_RELEASED;
                end else begin
                    n_action = sva_pkg::ACT_NOT_FOUND;
                end
            end
            sva_pkg::REQ_TICK: begin
                w_cmd.tick = w_commit;
                n_action   = sva_pkg::ACT_AGED;
            end
            sva_pkg::REQ_VOICE_DONE: begin
                // a slot past the table matches no cell
                w_cmd.free = w_commit;
                w_cmd.idx  = {{(sva_pkg::IDX_W-sva_pkg::SLOT_W){1'b0}}, w_last.slot};
                n_chosen   = {{(sva_pkg::IDX_W-sva_pkg::SLOT_W){1'b0}}, w_last.slot};
                n_action   = sva_pkg::ACT_FREED;
                n_count    = w_last.count - sva_pkg::CNT_W'(w_last.slot_active);
            end
            default: begin
                n_action = sva_pkg::ACT_ALL_RELEASED;
            end
        endcase
    end

    // control and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_o_valid <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (w_in_beat && w_known) begin
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (w_commit) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
            if (w_commit) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_commit) begin
            r_chosen <= n_chosen;
            r_action <= n_action;
            r_count  <= n_count;
        end
    end

    assign o_valid         = r_o_valid;
    assign o_voice_chosen  = r_chosen[sva_pkg::OUT_IDX_W-1:0];
    assign o_action        = r_action;
    assign o_active_voices = r_count[sva_pkg::OUT_CNT_W-1:0];

    // at most one search token in the chain
    a_one_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_chain_valid))
        else $error("more than one token in the voice chain");

    // a result appears only when a token has reached the tail
    a_result_from_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_o_valid) |-> $past(w_last.valid))
        else $error("result loaded without a finished scan");

    // reported count never exceeds the voice table
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid |-> (r_count <= sva_pkg::CNT_W'(VOICES)))
        else $error("active count beyond voice table");

    // no new request enters while a token is in flight
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (|w_chain_valid) |-> !o_ready)
        else $error("request taken during a scan");

endmodule

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the voice allocator: a queued driver, a randomly
// stalling receiver and a monitor compare every result beat with a predicted
// voice table
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_VOICES   = 8;
    localparam int ITEM_TARGET  = 1850;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int DRAIN_CYCLES = 4 * (NUM_VOICES + 1);
    localparam int HOLD_AFTER   = 300;
    localparam int HOLD_CYCLES  = 500;
    localparam int MAX_REPORTS  = 10;
    localparam int POOL_SIZE    = 16;

    // request codes past all_off are accepted and give no result
    localparam logic [sva_pkg::REQ_W-1:0] REQ_FIRST_UNUSED = sva_pkg::REQ_ALL_OFF + 1'b1;
    localparam logic [sva_pkg::REQ_W-1:0] REQ_TOP_CODE     = '1;

    typedef struct packed {
        logic [sva_pkg::REQ_W-1:0]  req;
        logic [sva_pkg::NOTE_W-1:0] note;
        logic [sva_pkg::SLOT_W-1:0] slot;
    } t_voice_req;

    typedef struct packed {
        logic [sva_pkg::OUT_IDX_W-1:0] chosen;
        logic [sva_pkg::ACT_W-1:0]     action;
        logic [sva_pkg::OUT_CNT_W-1:0] active;
    } t_voice_res;

    // every input known from time zero
    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic i_ready = 1'b0;
    logic [sva_pkg::REQ_W-1:0]  i_req_type    = '0;
    logic [sva_pkg::NOTE_W-1:0] i_note_number = '0;
    logic [sva_pkg::SLOT_W-1:0] i_voice_slot  = '0;

    logic                          o_ready;
    logic                          o_valid;
    logic [sva_pkg::OUT_IDX_W-1:0] o_voice_chosen;
    logic [sva_pkg::ACT_W-1:0]     o_action;
    logic [sva_pkg::OUT_CNT_W-1:0] o_active_voices;

    synth_voice_allocator #(
        .VOICES(NUM_VOICES)
    ) i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_req_type     (i_req_type),
        .i_note_number  (i_note_number),
        .i_voice_slot   (i_voice_slot),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_voice_chosen (o_voice_chosen),
        .o_action       (o_action),
        .o_active_voices(o_active_voices)
    );

    always #6 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // predicted voice table
    // ------------------------------------------------------------------------
    bit                         voice_on  [NUM_VOICES];
    logic [sva_pkg::NOTE_W-1:0] voice_key [NUM_VOICES];
    logic [sva_pkg::AGE_W-1:0]  voice_age [NUM_VOICES];

    t_voice_req pending_requests[$];
    t_voice_res expected_results[$];

    logic [sva_pkg::NOTE_W-1:0] note_pool[POOL_SIZE];

    int stim_useful   = 0;
    int stim_ignored  = 0;
    int sent_count    = 0;
    int results_seen  = 0;
    int fail_count    = 0;
    int cycle_count   = 0;
    int action_seen[8];

    // applies one request beat to the table, returns 1 when a result follows
    function automatic bit allocate_step(input t_voice_req rq, output t_voice_res res);
        int hit;
        int best;
        int n;
        logic [sva_pkg::AGE_W-1:0] best_age;
        hit      = -1;
        best     = -1;
        n        = 0;
        best_age = '0;
        res      = '0;
        case (rq.req)
            sva_pkg::REQ_NOTE_ON: begin
                for (int v = 0; v < NUM_VOICES; v++) begin
                    if (!voice_on[v] && hit < 0) hit = v;
                end
                if (hit >= 0) begin
                    res.action = sva_pkg::ACT_FREE_START;
                end else begin
                    // oldest wins, strictly greater so the lowest index keeps a tie
                    for (int v = 0; v < NUM_VOICES; v++) begin
                        if (voice_age[v] > best_age) begin
                            best_age = voice_age[v];
                            best     = v;
                        end
                    end
                    if (best >= 0) begin
                        hit        = best;
                        res.action = sva_pkg::ACT_STOLEN;
                    end else begin
                        res.action = sva_pkg::ACT_DROPPED;
                    end
                end
                if (hit >= 0) begin
                    voice_on[hit]  = 1'b1;
                    voice_key[hit] = rq.note;
                    voice_age[hit] = '0;
                    res.chosen     = sva_pkg::OUT_IDX_W'(hit);
                end
            end
            sva_pkg::REQ_NOTE_OFF: begin
                res.action = sva_pkg::ACT_NOT_FOUND;
                for (int v = 0; v < NUM_VOICES; v++) begin
                    if (hit < 0 && voice_on[v] && voice_key[v] == rq.note) hit = v;
                end
                if (hit >= 0) begin
                    res.action = sva_pkg::ACT_RELEASED;
                    res.chosen = sva_pkg::OUT_IDX_W'(hit);
                end
            end
            sva_pkg::REQ_TICK: begin
                for (int v = 0; v < NUM_VOICES; v++) begin
                    if (voice_on[v] && voice_age[v] != sva_pkg::AGE_MAX) begin
                        voice_age[v] = voice_age[v] + 1'b1;
                    end
                end
                res.action = sva_pkg::ACT_AGED;
            end
            sva_pkg::REQ_VOICE_DONE: begin
                if (rq.slot < NUM_VOICES) voice_on[rq.slot] = 1'b0;
                res.chosen = sva_pkg::OUT_IDX_W'(rq.slot);
                res.action = sva_pkg::ACT_FREED;
            end
            sva_pkg::REQ_ALL_OFF: begin
                res.action = sva_pkg::ACT_ALL_RELEASED;
            end
            default: begin
                return 1'b0;
            end
        endcase
        for (int v = 0; v < NUM_VOICES; v++) begin
            if (voice_on[v]) n++;
        end
        res.active = sva_pkg::OUT_CNT_W'(n);
        return 1'b1;
    endfunction

    // idle length: mostly none or short, a few long, some quiet stretches, and none in every fourth run of 250
    function automatic int pick_idle(input int progress);
        int r;
        if ((progress / 250) % 4 == 3) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // notes mostly from a small pool so that note-offs find their voices
    function automatic logic [sva_pkg::NOTE_W-1:0] pick_note();
        if ($urandom_range(0, 99) < 75) return note_pool[$urandom_range(0, POOL_SIZE - 1)];
        return sva_pkg::NOTE_W'($urandom_range(0, 127));
    endfunction

    task automatic queue_req(input logic [sva_pkg::REQ_W-1:0] rq,
                             input logic [sva_pkg::NOTE_W-1:0] nt,
                             input logic [sva_pkg::SLOT_W-1:0] sl);
        t_voice_req item;
        item.req  = rq;
        item.note = nt;
        item.slot = sl;
        pending_requests.push_back(item);
        if (rq > sva_pkg::REQ_ALL_OFF) stim_ignored++;
        else stim_useful++;
    endtask

    // ------------------------------------------------------------------------
    // request driver
    // ------------------------------------------------------------------------
    t_voice_req req_now;
    t_voice_res res_next;
    int         send_idle = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                if (allocate_step(req_now, res_next)) expected_results.push_back(res_next);
                sent_count++;
                send_idle = pick_idle(sent_count);
            end
            // a beat still on offer holds valid and payload
            if (!i_valid || o_ready) begin
                if (send_idle > 0) begin
                    send_idle--;
                    i_valid <= 1'b0;
                end else if (pending_requests.size() > 0) begin
                    req_now        = pending_requests.pop_front();
                    i_valid       <= 1'b1;
                    i_req_type    <= req_now.req;
                    i_note_number <= req_now.note;
                    i_voice_slot  <= req_now.slot;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // result receiver: random stalls plus one long hold-off so the result
    // register stays full and the request side backs up
    // ------------------------------------------------------------------------
    int recv_idle = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            i_ready <= 1'b0;
        end else if (!hold_done && results_seen >= HOLD_AFTER) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            i_ready  <= 1'b0;
        end else if (recv_idle > 0) begin
            recv_idle--;
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
            if (o_valid && i_ready) recv_idle = pick_idle(results_seen + 125);
        end
    end

    // ------------------------------------------------------------------------
    // result monitor
    // ------------------------------------------------------------------------
    t_voice_res res_got;
    t_voice_res res_want;

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            results_seen++;
            res_got.chosen = o_voice_chosen;
            res_got.action = o_action;
            res_got.active = o_active_voices;
            action_seen[o_action]++;
            if (expected_results.size() == 0) begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                    $display("result beat %0d unexpected: chosen %0d action %0d active %0d",
                             results_seen, res_got.chosen, res_got.action, res_got.active);
            end else begin
                res_want = expected_results.pop_front();
                if (res_got !== res_want) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS) begin
                        $display("result beat %0d mismatch: expected chosen %0d action %0d active %0d",
                                 results_seen, res_want.chosen, res_want.action,
                                 res_want.active);
                        $display("    got chosen %0d action %0d active %0d",
                                 res_got.chosen, res_got.action, res_got.active);
                    end
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("synth_voice_allocator verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // stimulus and end of run
    // ------------------------------------------------------------------------
    initial begin
        int kind;
        int k;
        int t;
        logic [sva_pkg::NOTE_W-1:0] chord[$];
        logic [sva_pkg::NOTE_W-1:0] nt;

        for (int v = 0; v < NUM_VOICES; v++) begin
            voice_on[v]  = 1'b0;
            voice_key[v] = '0;
            voice_age[v] = '0;
        end
        for (int a = 0; a < 8; a++) action_seen[a] = 0;
        for (int p = 0; p < POOL_SIZE; p++) begin
            note_pool[p] = sva_pkg::NOTE_W'($urandom_range(0, 127));
        end

        // directed: miss on an empty table, free an idle voice
        queue_req(sva_pkg::REQ_NOTE_OFF, 7'd5, '0);
        queue_req(sva_pkg::REQ_VOICE_DONE, '0, 3'd0);
        // fill every voice, note extremes included
        queue_req(sva_pkg::REQ_NOTE_ON, 7'd0, '0);
        queue_req(sva_pkg::REQ_NOTE_ON, 7'd127, '0);
        for (int n = 60; n < 66; n++) queue_req(sva_pkg::REQ_NOTE_ON, sva_pkg::NOTE_W'(n), '0);
        // table full and all ages zero: dropped
        queue_req(sva_pkg::REQ_NOTE_ON, 7'd42, '0);
        // equal ages steal the lowest voice
        queue_req(sva_pkg::REQ_TICK, '0, '0);
        queue_req(sva_pkg::REQ_NOTE_ON, 7'd85, '0);
        // now the oldest is voice one
        queue_req(sva_pkg::REQ_TICK, '0, '0);
        queue_req(sva_pkg::REQ_NOTE_ON, 7'd86, '0);
        queue_req(sva_pkg::REQ_NOTE_OFF, 7'd60, '0);
        // stolen note no longer held anywhere
        queue_req(sva_pkg::REQ_NOTE_OFF, 7'd127, '0);
        queue_req(sva_pkg::REQ_ALL_OFF, '0, '0);
        queue_req(sva_pkg::REQ_VOICE_DONE, '0, 3'd7);
        queue_req(sva_pkg::REQ_VOICE_DONE, '0, 3'd3);
        queue_req(sva_pkg::REQ_NOTE_ON, 7'd100, '0);
        // unused codes, accepted without a result
        for (int c = REQ_FIRST_UNUSED; c <= REQ_TOP_CODE; c++)
            queue_req(sva_pkg::REQ_W'(c), 7'h55, 3'd5);
        queue_req(sva_pkg::REQ_NOTE_OFF, 7'd100, '0);

        // random: mostly short phrases, some tick runs, full clears, noise and all-off pairs
        while (stim_useful + stim_ignored < ITEM_TARGET) begin
            kind = $urandom_range(0, 99);
            if (kind < 50) begin
                if ($urandom_range(0, 9) == 0)
                    note_pool[$urandom_range(0, POOL_SIZE - 1)] =
                        sva_pkg::NOTE_W'($urandom_range(0, 127));
                k = $urandom_range(1, 4);
                chord = {};
                for (int i = 0; i < k; i++) begin
                    nt = pick_note();
                    chord.push_back(nt);
                    queue_req(sva_pkg::REQ_NOTE_ON, nt, sva_pkg::SLOT_W'($urandom_range(0, 7)));
                end
                t = $urandom_range(0, 3);
                for (int i = 0; i < t; i++) queue_req(sva_pkg::REQ_TICK, pick_note(), '0);
                foreach (chord[i]) begin
                    if ($urandom_range(0, 3) != 0) queue_req(sva_pkg::REQ_NOTE_OFF, chord[i], '0);
                end
                for (int i = 0; i < k; i++) begin
                    if ($urandom_range(0, 2) != 0)
                        queue_req(sva_pkg::REQ_VOICE_DONE, pick_note(),
                                  sva_pkg::SLOT_W'($urandom_range(0, 7)));
                end
            end else if (kind < 72) begin
                t = $urandom_range(1, 6);
                for (int i = 0; i < t; i++) queue_req(sva_pkg::REQ_TICK, '0, '0);
            end else if (kind < 80) begin
                // free everything, then refill without ticks so any note-on beyond the table drops
                for (int s = 0; s < NUM_VOICES; s++) begin
                    queue_req(sva_pkg::REQ_VOICE_DONE, '0, sva_pkg::SLOT_W'(s));
                end
                t = $urandom_range(NUM_VOICES, NUM_VOICES + 2);
                for (int i = 0; i < t; i++) queue_req(sva_pkg::REQ_NOTE_ON, pick_note(), '0);
            end else if (kind < 90) begin
                queue_req(sva_pkg::REQ_W'($urandom_range(REQ_FIRST_UNUSED, REQ_TOP_CODE)),
                          pick_note(), '0);
            end else begin
                queue_req(sva_pkg::REQ_ALL_OFF, pick_note(), '0);
                queue_req(sva_pkg::REQ_NOTE_OFF, pick_note(), '0);
            end
        end

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        while (pending_requests.size() != 0 || i_valid || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        fail_count += expected_results.size();

        $display("ran %0d request beats (%0d with unused codes) into %0d result beats",
                 sent_count, stim_ignored, results_seen);
        $display("seen: %0d free starts, %0d steals, %0d drops, %0d releases",
                 action_seen[sva_pkg::ACT_FREE_START], action_seen[sva_pkg::ACT_STOLEN],
                 action_seen[sva_pkg::ACT_DROPPED], action_seen[sva_pkg::ACT_RELEASED]);
        $display("      %0d misses, %0d ticks, %0d frees, %0d all-offs",
                 action_seen[sva_pkg::ACT_NOT_FOUND], action_seen[sva_pkg::ACT_AGED],
                 action_seen[sva_pkg::ACT_FREED], action_seen[sva_pkg::ACT_ALL_RELEASED]);
        if (fail_count == 0) begin
            $display("synth_voice_allocator verification clean");
        end else begin
            $display("synth_voice_allocator verification failed");
        end
        $finish;
    end

endmodule
